// ===== rtl/csx_pkg.sv =====
// Shared constants, types and helpers for the clocked serial transceiver.
`default_nettype none
package csx_pkg;

    localparam int RING_DEPTH = 16;
    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int BYTE_W = 8;
    localparam int AVAIL_W = 4;
    localparam int BIT_CNT_W = 3;

    localparam logic [1:0] ACT_CLOCK = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;
    localparam logic [1:0] ACT_PEEK = 2'd3;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic               tx_pin;
        logic               read_valid;
        logic               write_accepted;
        logic [AVAIL_W-1:0] rx_available;
        logic               tx_drained;
        logic               rx_error;
    } t_result;

    function automatic t_idx f_next_index(input t_idx i);
        t_idx r;
        if (i == IDX_W'(RING_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = i + 1'b1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/csx_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module csx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/clocked_serial_transceiver_fifo.sv =====
// Top level: 8N1 serial transceiver with transmit and receive rings in RAM.
// An input transfer reaches its result transfer through a middle stage and an output register.
// Throughput is one item per cycle while i_out_stall is low; a stalled output stalls the input.
// Reset is synchronous and active low; it clears indices, flags and valids.
// Ring contents are not cleared, so no clearing pass follows reset.
`default_nettype none
module clocked_serial_transceiver_fifo
    import csx_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_action,
    input  wire logic               i_rx_pin,
    input  wire logic [BYTE_W-1:0]  i_write_byte,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_tx_pin,
    output logic [BYTE_W-1:0]       o_read_data,
    output logic                    o_read_valid,
    output logic                    o_write_accepted,
    output logic [AVAIL_W-1:0]      o_rx_available,
    output logic                    o_tx_drained,
    output logic                    o_rx_error
);

    t_idx                 r_tx_wi, n_tx_wi, r_tx_ri, n_tx_ri;
    logic [BYTE_W-1:0]    r_tx_shift, n_tx_shift;
    logic [BIT_CNT_W-1:0] r_tx_cnt, n_tx_cnt;
    logic                 r_tx_busy, n_tx_busy, r_tx_fe, n_tx_fe;
    logic                 r_tx_level, n_tx_level, r_tx_pend, n_tx_pend;

    t_idx                 r_rx_wi, n_rx_wi, r_rx_ri, n_rx_ri;
    logic [BYTE_W-1:0]    r_rx_shift, n_rx_shift;
    logic [BIT_CNT_W-1:0] r_rx_cnt, n_rx_cnt;
    logic                 r_rx_busy, n_rx_busy, r_rx_await, n_rx_await;
    logic                 r_rx_err, n_rx_err;

    logic                 r_s1_valid, r_out_valid;
    t_result              r_s1_res, n_res, r_out_res;
    logic [BYTE_W-1:0]    r_out_data;

    logic                 out_free, s1_move, in_acc;
    logic [BYTE_W-1:0]    tx_rdata, rx_rdata, tx_eff_shift;
    logic                 tx_re, tx_we, rx_re, rx_we;
    t_idx                 tx_nxt, rx_nxt;
    logic [IDX_W:0]       avail;

    assign out_free = !r_out_valid || !i_out_stall;
    assign s1_move = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_acc = i_in_valid && !o_in_stall;

    assign tx_eff_shift = r_tx_pend ? tx_rdata : r_tx_shift;
    assign tx_nxt = f_next_index(r_tx_wi);
    assign rx_nxt = f_next_index(r_rx_wi);

    csx_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_tx_ram (
        .i_clk  (i_clk),
        .i_we   (tx_we),
        .i_waddr(r_tx_wi),
        .i_wdata(i_write_byte),
        .i_re   (tx_re),
        .i_raddr(r_tx_ri),
        .o_rdata(tx_rdata)
    );

    csx_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_rx_ram (
        .i_clk  (i_clk),
        .i_we   (rx_we),
        .i_waddr(r_rx_wi),
        .i_wdata(r_rx_shift),
        .i_re   (rx_re),
        .i_raddr(r_rx_ri),
        .o_rdata(rx_rdata)
    );

    always_comb begin
        n_tx_wi = r_tx_wi;
        n_tx_ri = r_tx_ri;
        n_tx_shift = tx_eff_shift;
        n_tx_cnt = r_tx_cnt;
        n_tx_busy = r_tx_busy;
        n_tx_fe = r_tx_fe;
        n_tx_level = r_tx_level;
        n_tx_pend = 1'b0;
        n_rx_wi = r_rx_wi;
        n_rx_ri = r_rx_ri;
        n_rx_shift = r_rx_shift;
        n_rx_cnt = r_rx_cnt;
        n_rx_busy = r_rx_busy;
        n_rx_await = r_rx_await;
        n_rx_err = r_rx_err;
        tx_re = 1'b0;
        tx_we = 1'b0;
        rx_re = 1'b0;
        rx_we = 1'b0;
        n_res = '0;

        case (i_action)
            ACT_CLOCK: begin
                if (r_tx_busy) begin
                    if (r_tx_fe) begin
                        n_tx_level = 1'b1;
                        if (r_tx_wi == r_tx_ri) begin
                            n_tx_fe = 1'b0;
                        end
                        n_tx_busy = 1'b0;
                    end else begin
                        n_tx_level = tx_eff_shift[0];
                        n_tx_shift = tx_eff_shift >> 1;
                        n_tx_cnt = r_tx_cnt + 1'b1;
                        if (r_tx_cnt == '1) begin
                            n_tx_fe = 1'b1;
                        end
                    end
                end else if (r_tx_fe) begin
                    tx_re = in_acc;
                    n_tx_pend = 1'b1;
                    n_tx_ri = f_next_index(r_tx_ri);
                    n_tx_level = 1'b0;
                    n_tx_cnt = '0;
                    n_tx_fe = 1'b0;
                    n_tx_busy = 1'b1;
                end

                if (r_rx_await) begin
                    if (i_rx_pin) begin
                        if (rx_nxt == r_rx_ri) begin
                            n_rx_err = 1'b1;
                        end else begin
                            rx_we = in_acc;
                            n_rx_wi = rx_nxt;
                        end
                    end else begin
                        n_rx_err = 1'b1;
                    end
                    n_rx_busy = 1'b0;
                    n_rx_await = 1'b0;
                end else if (r_rx_busy) begin
                    n_rx_shift = {i_rx_pin, r_rx_shift[BYTE_W-1:1]};
                    n_rx_cnt = r_rx_cnt + 1'b1;
                    if (r_rx_cnt == '1) begin
                        n_rx_await = 1'b1;
                    end
                end else if (!i_rx_pin) begin
                    n_rx_shift = '0;
                    n_rx_cnt = '0;
                    n_rx_busy = 1'b1;
                end
            end
            ACT_WRITE: begin
                if (tx_nxt != r_tx_ri) begin
                    tx_we = in_acc;
                    n_tx_wi = tx_nxt;
                    if (!r_tx_busy) begin
                        n_tx_fe = 1'b1;
                    end
                    n_res.write_accepted = 1'b1;
                end
            end
            ACT_READ, ACT_PEEK: begin
                if (r_rx_wi != r_rx_ri) begin
                    rx_re = in_acc;
                    n_res.read_valid = 1'b1;
                    if (i_action == ACT_READ) begin
                        n_rx_ri = f_next_index(r_rx_ri);
                    end
                end
            end
            default: begin
            end
        endcase

        if (n_rx_wi >= n_rx_ri) begin
            avail = {1'b0, n_rx_wi} - {1'b0, n_rx_ri};
        end else begin
            avail = {1'b0, n_rx_wi} + (IDX_W+1)'(RING_DEPTH) - {1'b0, n_rx_ri};
        end
        n_res.tx_pin = n_tx_level;
        n_res.rx_available = AVAIL_W'(avail);
        n_res.tx_drained = (n_tx_wi == n_tx_ri);
        n_res.rx_error = n_rx_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_wi <= '0;
            r_tx_ri <= '0;
            r_tx_shift <= '0;
            r_tx_cnt <= '0;
            r_tx_busy <= 1'b0;
            r_tx_fe <= 1'b0;
            r_tx_level <= 1'b1;
            r_tx_pend <= 1'b0;
            r_rx_wi <= '0;
            r_rx_ri <= '0;
            r_rx_shift <= '0;
            r_rx_cnt <= '0;
            r_rx_busy <= 1'b0;
            r_rx_await <= 1'b0;
            r_rx_err <= 1'b0;
        end else if (in_acc) begin
            r_tx_wi <= n_tx_wi;
            r_tx_ri <= n_tx_ri;
            r_tx_shift <= n_tx_shift;
            r_tx_cnt <= n_tx_cnt;
            r_tx_busy <= n_tx_busy;
            r_tx_fe <= n_tx_fe;
            r_tx_level <= n_tx_level;
            r_tx_pend <= n_tx_pend;
            r_rx_wi <= n_rx_wi;
            r_rx_ri <= n_rx_ri;
            r_rx_shift <= n_rx_shift;
            r_rx_cnt <= n_rx_cnt;
            r_rx_busy <= n_rx_busy;
            r_rx_await <= n_rx_await;
            r_rx_err <= n_rx_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_res <= n_res;
        end
        if (s1_move) begin
            r_out_res <= r_s1_res;
            r_out_data <= r_s1_res.read_valid ? rx_rdata : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_pin = r_out_res.tx_pin;
    assign o_read_data = r_out_data;
    assign o_read_valid = r_out_res.read_valid;
    assign o_write_accepted = r_out_res.write_accepted;
    assign o_rx_available = r_out_res.rx_available;
    assign o_tx_drained = r_out_res.tx_drained;
    assign o_rx_error = r_out_res.rx_error;

`ifndef SYNTHESIS
    a_stall_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("Input stalled with an empty middle stage.");

    a_pend_implies_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_pend |-> r_tx_busy)
        else $error("Transmit load pending while the transmitter is idle.");

    a_read_write_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_read_valid && o_write_accepted))
        else $error("Result reports both a read and a write.");

    a_write_fills_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && tx_we) |=> (r_tx_wi != r_tx_ri))
        else $error("Transmit ring empty after an accepted write.");
`endif

endmodule
`default_nettype wire
